// ----- rtl/dbd_pkg.sv -----
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants of the detection box decoder.
// ----------------------------------------------------------------------------
package dbd_pkg;

  // elements 0..3 of a box are centre x, centre y, width, height
  localparam int unsigned CoordCount = 4;
  localparam int unsigned MaxClasses = 128;

  // configuration register indexes
  localparam logic [2:0] RegScoreThreshold = 3'd0;
  localparam logic [2:0] RegPadLeft        = 3'd1;
  localparam logic [2:0] RegPadTop         = 3'd2;
  localparam logic [2:0] RegInverseScale   = 3'd3;
  localparam logic [2:0] RegImageWidth     = 3'd4;
  localparam logic [2:0] RegImageHeight    = 3'd5;
  localparam logic [2:0] RegClassCount     = 3'd6;

  // reset values
  localparam logic [13:0] RstScoreThreshold = 14'd2048;
  localparam logic [9:0]  RstPadLeft        = 10'd0;
  localparam logic [9:0]  RstPadTop         = 10'd0;
  localparam logic [19:0] RstInverseScale   = 20'd65536;
  localparam logic [13:0] RstImageWidth     = 14'd640;
  localparam logic [13:0] RstImageHeight    = 14'd640;
  localparam logic [7:0]  RstClassCount     = 8'd80;

  typedef struct packed {
    logic [13:0] score_threshold;
    logic [9:0]  pad_left;
    logic [9:0]  pad_top;
    logic [19:0] inverse_scale;
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic [7:0]  class_count;
  } cfg_t;

  // box captured at the last element
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] w;
    logic signed [23:0] h;
    logic [22:0]        score;
    logic [6:0]         class_index;
  } box_t;

  // raw products, Q.29
  typedef struct packed {
    logic signed [45:0] px;
    logic signed [45:0] py;
    logic signed [45:0] pw;
    logic signed [45:0] ph;
    logic [22:0]        score;
    logic [6:0]         class_index;
  } prod_t;

  // scaled values, Q.13
  typedef struct packed {
    logic signed [29:0] xc;
    logic signed [29:0] yc;
    logic signed [29:0] wd;
    logic signed [29:0] ht;
    logic [22:0]        score;
    logic [6:0]         class_index;
  } scaled_t;

  // integer corner and size before clamping
  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic signed [16:0] w_int;
    logic signed [16:0] h_int;
    logic [22:0]        score;
    logic [6:0]         class_index;
  } raw_t;

  // result, first field in the high bits
  typedef struct packed {
    logic [22:0] score;
    logic [6:0]  class_index;
    logic [13:0] box_height;
    logic [13:0] box_width;
    logic [12:0] top;
    logic [12:0] left;
  } result_t;

endpackage

// ----- rtl/dbd_accum.sv -----
// ----------------------------------------------------------------------------
// dbd_accum
// Per-box running state: coordinate capture, argmax of class scores and the
// keep decision on the last element. Kept boxes go to a one-entry stage.
// ----------------------------------------------------------------------------
module dbd_accum import dbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] in_value_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output box_t               out_box_o
);

  localparam logic [7:0] MaxClassesC = 8'(MaxClasses);
  localparam logic [7:0] CoordCountC = 8'(CoordCount);

  logic [7:0]         pos_q, pos_d;
  logic signed [23:0] best_q, best_d;
  logic [6:0]         cls_q, cls_d;
  logic               found_q, found_d;
  logic signed [23:0] crd_q [CoordCount];
  logic signed [23:0] crd_d [CoordCount];
  logic               box_v_q, box_v_d;
  box_t               box_q, box_d;

  logic [7:0] cap;
  logic [7:0] cls_idx;
  logic       is_score;
  logic       better;
  logic       keep;
  logic       accept;

  assign in_ready_o  = !box_v_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = box_v_q;
  assign out_box_o   = box_q;

  always_comb begin
    cap      = (cfg_i.class_count > MaxClassesC) ? MaxClassesC : cfg_i.class_count;
    cls_idx  = pos_q - CoordCountC;
    is_score = (pos_q >= CoordCountC) && (cls_idx < cap);
    better   = is_score && (in_value_i > best_q);
    best_d   = better ? in_value_i : best_q;
    cls_d    = better ? cls_idx[6:0] : cls_q;
    found_d  = found_q || better;
    for (int i = 0; i < CoordCount; i++) begin
      crd_d[i] = (pos_q == 8'(i)) ? in_value_i : crd_q[i];
    end
    pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
    keep  = found_d && (best_d >= $signed({10'b0, cfg_i.score_threshold}));

    box_d.cx          = crd_d[0];
    box_d.cy          = crd_d[1];
    box_d.w           = crd_d[2];
    box_d.h           = crd_d[3];
    box_d.score       = best_d[22:0];
    box_d.class_index = cls_d;

    if (in_ready_o) begin
      box_v_d = accept && in_last_i && keep;
    end else begin
      box_v_d = box_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      best_q  <= '0;
      cls_q   <= '0;
      found_q <= 1'b0;
      box_v_q <= 1'b0;
      for (int i = 0; i < CoordCount; i++) begin
        crd_q[i] <= '0;
      end
    end else begin
      box_v_q <= box_v_d;
      if (accept) begin
        if (in_last_i) begin
          // every box starts from a clean slate
          pos_q   <= '0;
          best_q  <= '0;
          cls_q   <= '0;
          found_q <= 1'b0;
          for (int i = 0; i < CoordCount; i++) begin
            crd_q[i] <= '0;
          end
        end else begin
          pos_q   <= pos_d;
          best_q  <= best_d;
          cls_q   <= cls_d;
          found_q <= found_d;
          for (int i = 0; i < CoordCount; i++) begin
            crd_q[i] <= crd_d[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_last_i && keep) begin
      box_q <= box_d;
    end
  end

endmodule

// ----- rtl/dbd_scale.sv -----
// ----------------------------------------------------------------------------
// dbd_scale
// Padding removal and multiplication by the inverse scale, then division
// by 2^16 truncating toward zero. Two pipeline stages.
// ----------------------------------------------------------------------------
module dbd_scale import dbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  box_t    in_box_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output scaled_t out_data_o
);

  logic    prod_v_q, scl_v_q;
  logic    prod_rdy, scl_rdy;
  prod_t   prod_q, prod_d;
  scaled_t scl_q, scl_d;

  logic signed [24:0] dx, dy;
  logic signed [24:0] w_ext, h_ext;
  logic signed [20:0] inv;

  function automatic logic signed [29:0] trunc_q16(input logic signed [45:0] p);
    logic signed [45:0] s;
    begin
      s = p + $signed({30'b0, {16{p[45]}}});
      return s[45:16];
    end
  endfunction

  assign prod_rdy    = !prod_v_q || scl_rdy;
  assign scl_rdy     = !scl_v_q || out_ready_i;
  assign in_ready_o  = prod_rdy;
  assign out_valid_o = scl_v_q;
  assign out_data_o  = scl_q;

  always_comb begin
    inv   = $signed({1'b0, cfg_i.inverse_scale});
    dx    = $signed({in_box_i.cx[23], in_box_i.cx}) - $signed({2'b0, cfg_i.pad_left, 13'b0});
    dy    = $signed({in_box_i.cy[23], in_box_i.cy}) - $signed({2'b0, cfg_i.pad_top, 13'b0});
    w_ext = {in_box_i.w[23], in_box_i.w};
    h_ext = {in_box_i.h[23], in_box_i.h};

    prod_d.px          = dx * inv;
    prod_d.py          = dy * inv;
    prod_d.pw          = w_ext * inv;
    prod_d.ph          = h_ext * inv;
    prod_d.score       = in_box_i.score;
    prod_d.class_index = in_box_i.class_index;

    scl_d.xc          = trunc_q16(prod_q.px);
    scl_d.yc          = trunc_q16(prod_q.py);
    scl_d.wd          = trunc_q16(prod_q.pw);
    scl_d.ht          = trunc_q16(prod_q.ph);
    scl_d.score       = prod_q.score;
    scl_d.class_index = prod_q.class_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      scl_v_q  <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_v_q <= in_valid_i;
      end
      if (scl_rdy) begin
        scl_v_q <= prod_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (scl_rdy && prod_v_q) begin
      scl_q <= scl_d;
    end
  end

endmodule

// ----- rtl/dbd_clamp.sv -----
// ----------------------------------------------------------------------------
// dbd_clamp
// Centre to corner conversion, clamping into the image and size limiting.
// The second stage is the result register seen on the output channel.
// ----------------------------------------------------------------------------
module dbd_clamp import dbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  scaled_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    raw_v_q, res_v_q;
  logic    raw_rdy, res_rdy;
  raw_t    raw_q, raw_d;
  result_t res_q, res_d;

  logic signed [31:0] sx, sy;

  function automatic logic [12:0] clamp_corner(input logic signed [17:0] c,
                                               input logic [13:0] lim);
    logic signed [18:0] cx;
    logic signed [18:0] lm;
    begin
      cx = {c[17], c};
      lm = $signed({5'b0, lim}) - 19'sd1;
      if (cx > lm) cx = lm;
      if (cx < 19'sd0) cx = 19'sd0;
      if (cx > 19'sd8191) cx = 19'sd8191;
      return cx[12:0];
    end
  endfunction

  function automatic logic [13:0] limit_size(input logic signed [16:0] s,
                                             input logic [13:0] lim,
                                             input logic [12:0] corner);
    logic signed [18:0] sz;
    logic signed [18:0] room;
    begin
      sz   = {{2{s[16]}}, s};
      room = $signed({5'b0, lim}) - $signed({6'b0, corner});
      if (sz > room) sz = room;
      if (sz < 19'sd0) sz = 19'sd0;
      if (sz > 19'sd16383) sz = 19'sd16383;
      return sz[13:0];
    end
  endfunction

  assign raw_rdy     = !raw_v_q || res_rdy;
  assign res_rdy     = !res_v_q || out_ready_i;
  assign in_ready_o  = raw_rdy;
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  always_comb begin
    // 2*centre - size, then divide by 2^14 truncating toward zero
    sx = $signed({in_data_i.xc[29], in_data_i.xc, 1'b0})
       - $signed({{2{in_data_i.wd[29]}}, in_data_i.wd});
    sy = $signed({in_data_i.yc[29], in_data_i.yc, 1'b0})
       - $signed({{2{in_data_i.ht[29]}}, in_data_i.ht});
    sx = sx + $signed({18'b0, {14{sx[31]}}});
    sy = sy + $signed({18'b0, {14{sy[31]}}});

    raw_d.left        = sx[31:14];
    raw_d.top         = sy[31:14];
    raw_d.w_int       = 17'((in_data_i.wd + $signed({17'b0, {13{in_data_i.wd[29]}}})) >>> 13);
    raw_d.h_int       = 17'((in_data_i.ht + $signed({17'b0, {13{in_data_i.ht[29]}}})) >>> 13);
    raw_d.score       = in_data_i.score;
    raw_d.class_index = in_data_i.class_index;

    res_d.left        = clamp_corner(raw_q.left, cfg_i.image_width);
    res_d.top         = clamp_corner(raw_q.top, cfg_i.image_height);
    res_d.box_width   = limit_size(raw_q.w_int, cfg_i.image_width, res_d.left);
    res_d.box_height  = limit_size(raw_q.h_int, cfg_i.image_height, res_d.top);
    res_d.score       = raw_q.score;
    res_d.class_index = raw_q.class_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (raw_rdy) begin
        raw_v_q <= in_valid_i;
      end
      if (res_rdy) begin
        res_v_q <= raw_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_rdy && in_valid_i) begin
      raw_q <= raw_d;
    end
    if (res_rdy && raw_v_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- rtl/detection_box_decode_unit.sv -----
// ----------------------------------------------------------------------------
// detection_box_decode_unit
// Decodes one candidate box from a stream of detector head values.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q11.13 value per transfer: centre x, centre y,
//   width, height, then the class scores; tlast marks the box's final value.
//   A box whose best score is zero or below, or under the threshold, yields
//   nothing. A kept box yields one transfer on m_axis.
//   Throughput: one value per cycle while results are taken. The datapath
//   is a five register pipeline (box capture, product, scaled value, raw
//   corner, result); a kept box passes through them in that order. Each
//   stage holds its item while the next is full, so a stalled m_axis first
//   fills the pipeline, then drops s_axis_tready.
//   Configuration writes take effect at once and belong to idle periods.
//   Reset loads the default registers, clears the box state and empties the
//   pipeline; s_axis_tready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module detection_box_decode_unit import dbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [19:0] cfg_wdata_i,
  // input values
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] value
  input  logic        s_axis_tlast,   // last_value
  // decoded boxes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // left, top, box_width, box_height, class_index,
                                      // score, zero fill
);

  cfg_t    cfg_q, cfg_d;
  logic    box_v, box_rdy;
  box_t    box;
  logic    scl_v, scl_rdy;
  scaled_t scl;
  result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegScoreThreshold: cfg_d.score_threshold = cfg_wdata_i[13:0];
        RegPadLeft:        cfg_d.pad_left        = cfg_wdata_i[9:0];
        RegPadTop:         cfg_d.pad_top         = cfg_wdata_i[9:0];
        RegInverseScale:   cfg_d.inverse_scale   = cfg_wdata_i;
        RegImageWidth:     cfg_d.image_width     = cfg_wdata_i[13:0];
        RegImageHeight:    cfg_d.image_height    = cfg_wdata_i[13:0];
        RegClassCount:     cfg_d.class_count     = cfg_wdata_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= RstScoreThreshold;
      cfg_q.pad_left        <= RstPadLeft;
      cfg_q.pad_top         <= RstPadTop;
      cfg_q.inverse_scale   <= RstInverseScale;
      cfg_q.image_width     <= RstImageWidth;
      cfg_q.image_height    <= RstImageHeight;
      cfg_q.class_count     <= RstClassCount;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dbd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  ($signed(s_axis_tdata)),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (box_v),
    .out_ready_i (box_rdy),
    .out_box_o   (box)
  );

  dbd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (box_v),
    .in_ready_o  (box_rdy),
    .in_box_i    (box),
    .out_valid_o (scl_v),
    .out_ready_i (scl_rdy),
    .out_data_o  (scl)
  );

  dbd_clamp u_clamp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (scl_v),
    .in_ready_o  (scl_rdy),
    .in_data_i   (scl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {4'b0, res};

endmodule

// ----- rtl/dbd_checker.sv -----
// ----------------------------------------------------------------------------
// dbd_checker
// Port-level checks of the detection box decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // a stalled result keeps waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // and keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty result register lets every stage move, so input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a kept box always has a positive best score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[83:61] != 23'd0))
    else $error("result with zero score");

endmodule

bind detection_box_decode_unit dbd_checker u_dbd_checker (.*);

// ----- verif/dbd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbd_monitor
// Watches the register port and both streams of the detection box decoder,
// rebuilds every decoded box from the accepted values and compares each
// delivered box field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module dbd_monitor import dbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,    // [23:0] value
  input  logic        s_tlast_i,    // last_value
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [87:0] m_tdata_i,    // left, top, box_width, box_height, class_index,
                                    // score, zero fill
  output int          error_count_o,
  output int          boxes_due_o,
  output int          decoded_count_o,
  output int          dropped_count_o
);

  cfg_t               regs;
  logic [7:0]         elem_pos;
  logic signed [23:0] best_score;
  logic [6:0]         best_class;
  logic               class_found;
  logic signed [23:0] centre_size [CoordCount];
  result_t            boxes_due [$];

  initial begin
    error_count_o   = 0;
    boxes_due_o     = 0;
    decoded_count_o = 0;
    dropped_count_o = 0;
  end

  function automatic longint rescale(longint v);
    return (v * longint'(regs.inverse_scale)) / 65536;
  endfunction

  function automatic longint clamp_edge(longint c, longint lim);
    if (c > lim - 1) c = lim - 1;
    if (c < 0) c = 0;
    if (c > 8191) c = 8191;
    return c;
  endfunction

  function automatic longint fit_size(longint s, longint room);
    if (s > room) s = room;
    if (s < 0) s = 0;
    if (s > 16383) s = 16383;
    return s;
  endfunction

  task automatic clear_box();
    elem_pos    = '0;
    best_score  = '0;
    best_class  = '0;
    class_found = 1'b0;
    for (int i = 0; i < CoordCount; i++) centre_size[i] = '0;
  endtask

  task automatic decode_value(input logic signed [23:0] v, input logic last);
    int unsigned classes;
    longint      xc, yc, wd, ht, lft, tp, bw, bh;
    result_t     box;
    classes = (regs.class_count > MaxClasses) ? MaxClasses : regs.class_count;
    if (elem_pos < CoordCount) begin
      centre_size[elem_pos[1:0]] = v;
    end else if (elem_pos - CoordCount < classes) begin
      // strictly greater only: the first of equal scores wins
      if (v > best_score) begin
        best_score  = v;
        best_class  = 7'(elem_pos - CoordCount);
        class_found = 1'b1;
      end
    end
    if (elem_pos != 8'd255) elem_pos = elem_pos + 8'd1;
    if (!last) return;
    if (!class_found || longint'(best_score) < longint'(regs.score_threshold)) begin
      dropped_count_o++;
      clear_box();
      return;
    end
    xc  = rescale(longint'(centre_size[0]) - longint'(regs.pad_left) * 8192);
    yc  = rescale(longint'(centre_size[1]) - longint'(regs.pad_top) * 8192);
    wd  = rescale(longint'(centre_size[2]));
    ht  = rescale(longint'(centre_size[3]));
    lft = clamp_edge((2 * xc - wd) / 16384, longint'(regs.image_width));
    tp  = clamp_edge((2 * yc - ht) / 16384, longint'(regs.image_height));
    bw  = fit_size(wd / 8192, longint'(regs.image_width) - lft);
    bh  = fit_size(ht / 8192, longint'(regs.image_height) - tp);
    box.left        = lft[12:0];
    box.top         = tp[12:0];
    box.box_width   = bw[13:0];
    box.box_height  = bh[13:0];
    box.class_index = best_class;
    box.score       = best_score[22:0];
    boxes_due = {boxes_due, box};
    clear_box();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: box %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count_o++;
    end
  endtask

  task automatic check_box();
    result_t got, want;
    got = m_tdata_i[83:0];
    if (boxes_due.size() == 0) begin
      $display("%0t: unexpected box transfer, expected none, actual %h", $time, m_tdata_i);
      error_count_o++;
      return;
    end
    want = boxes_due.pop_front();
    decoded_count_o++;
    check_field("left", want.left, got.left);
    check_field("top", want.top, got.top);
    check_field("box_width", want.box_width, got.box_width);
    check_field("box_height", want.box_height, got.box_height);
    check_field("class_index", want.class_index, got.class_index);
    check_field("score", want.score, got.score);
    check_field("fill", 0, m_tdata_i[87:84]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{score_threshold: RstScoreThreshold, pad_left: RstPadLeft,
               pad_top: RstPadTop, inverse_scale: RstInverseScale,
               image_width: RstImageWidth, image_height: RstImageHeight,
               class_count: RstClassCount};
      clear_box();
      boxes_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegScoreThreshold: regs.score_threshold = cfg_wdata_i[13:0];
          RegPadLeft:        regs.pad_left        = cfg_wdata_i[9:0];
          RegPadTop:         regs.pad_top         = cfg_wdata_i[9:0];
          RegInverseScale:   regs.inverse_scale   = cfg_wdata_i[19:0];
          RegImageWidth:     regs.image_width     = cfg_wdata_i[13:0];
          RegImageHeight:    regs.image_height    = cfg_wdata_i[13:0];
          RegClassCount:     regs.class_count     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) decode_value(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_box();
    end
    boxes_due_o = boxes_due.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the detection box decoder: a few hand-built boxes, then
// random boxes under a series of register settings with random idle gaps
// on the value stream and random stalls on the box stream.
// ----------------------------------------------------------------------------
module tb_top;
  import dbd_pkg::*;

  localparam logic [2:0] RegUnused   = 3'd7;
  localparam int         IdleLimit   = 2000;
  localparam int         PhaseValues = 46;
  localparam int         PhaseCount  = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [19:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;

  int errors, pending, decoded, dropped;
  int values_sent  = 0;
  int boxes_sent   = 0;
  int reg_writes   = 0;
  int cur_classes  = RstClassCount;
  int cur_thr      = RstScoreThreshold;
  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;

  detection_box_decode_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  dbd_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tlast_i       (s_tlast),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .error_count_o   (errors),
    .boxes_due_o     (pending),
    .decoded_count_o (decoded),
    .dropped_count_o (dropped)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short pauses, now and then a long one
  function automatic int rand_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // box stream consumer
  initial begin : box_sink
    int hold;
    hold = 0;
    m_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        hold = rand_pause() - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("tb_top: timeout after %0d cycles without a transfer", IdleLimit);
    $display("tb_top: errors");
    $finish;
  end

  // one value transfer; returns on the falling edge after it
  task automatic send_value(input logic [23:0] v, input logic last);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      s_tvalid = 1'b0;
      repeat (rand_pause()) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tlast  = last;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    values_sent++;
  endtask

  task automatic send_coords(input logic [23:0] cx, cy, w, h);
    send_value(cx, 1'b0);
    send_value(cy, 1'b0);
    send_value(w, 1'b0);
    send_value(h, 1'b0);
  endtask

  // wait for every outstanding box plus the pipeline depth for dropped ones
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    reg_writes++;
    if (idx == RegClassCount) cur_classes = val[7:0];
    if (idx == RegScoreThreshold) cur_thr = val[13:0];
  endtask

  task automatic program_all(input int thr, pl, pt, sc, iw, ih, cc);
    program_reg(RegScoreThreshold, 20'(thr));
    program_reg(RegPadLeft, 20'(pl));
    program_reg(RegPadTop, 20'(pt));
    program_reg(RegInverseScale, 20'(sc));
    program_reg(RegImageWidth, 20'(iw));
    program_reg(RegImageHeight, 20'(ih));
    program_reg(RegClassCount, 20'(cc));
  endtask

  task automatic setup_phase(input int p);
    case (p)
      0: program_all(1, 0, 0, 65536, 640, 480, 2);
      1: program_all(8192, 1023, 1023, 1048575, 8192, 8192, 4);
      2: program_all($urandom_range(1, 8192), 0, 0, 1, 1, 1, 1);
      3: program_all($urandom_range(1, 4096), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(1, 1048575), $urandom_range(1, 8192),
                     $urandom_range(1, 8192), 128);
      4: begin
        // class count above the limit, masked pad write, write to a free index
        program_all($urandom_range(1, 4096), $urandom_range(0, 1023), 0, 65536, 1920, 1080,
                    255);
        program_reg(RegPadTop, 20'hFFFFF);
        program_reg(RegUnused, 20'($urandom));
      end
      default: program_all($urandom_range(1, 8192), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(1, 1048575),
                           $urandom_range(1, 8192), $urandom_range(1, 8192),
                           $urandom_range(1, 6));
    endcase
  endtask

  task automatic send_box();
    int          kind, n, i;
    bit          noise, quiet;
    logic [23:0] v, prev;
    if ($urandom_range(0, 19) == 0) drain();
    n = (cur_classes > MaxClasses) ? CoordCount + MaxClasses + 12 : CoordCount + cur_classes;
    kind  = $urandom_range(0, 99);
    noise = kind >= 92;
    quiet = $urandom_range(0, 9) == 0;
    if (kind >= 72 && kind < 84) n = $urandom_range(1, (n > 12) ? 12 : n - 1);
    else if (kind >= 84 && kind < 92) n = n + $urandom_range(1, 6);
    prev = '0;
    for (i = 0; i < n; i++) begin
      if (noise) begin
        v = 24'($urandom);
      end else if (i < CoordCount) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: v = 24'($urandom_range(0, 24'h7FFFFF));
          6, 7:             v = 24'($urandom_range(0, 131072) - 65536);
          default:          v = 24'($urandom);
        endcase
      end else if (quiet) begin
        v = 24'(-$urandom_range(0, 5000));
      end else begin
        case ($urandom_range(0, 9))
          0:       v = prev;
          1:       v = 24'($urandom);
          default: v = 24'($urandom_range(0, 3 * cur_thr + 16) - cur_thr / 2);
        endcase
      end
      prev = v;
      send_value(v, i == n - 1);
    end
    boxes_sent++;
  endtask

  initial begin : stimulus
    int p, start;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    program_reg(RegClassCount, 20'd3);
    // extreme coordinates, top score followed by an equal one that must not win
    send_coords(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_value(24'h7FFFFF, 1'b0);
    send_value(24'h7FFFFF, 1'b0);
    send_value(24'h000000, 1'b1);
    // best score exactly at the default threshold
    send_coords(24'h280000, 24'h1E0000, 24'h0C8000, 24'h0A0000);
    send_value(24'd2047, 1'b0);
    send_value(24'd2048, 1'b0);
    send_value(24'd100, 1'b1);
    // best score one below the threshold
    send_coords(24'h4FE000, 24'h4FE000, 24'h190000, 24'h190000);
    send_value(24'd2047, 1'b0);
    send_value(24'd0, 1'b0);
    send_value(24'h800000, 1'b1);
    // box cut short before its coordinates are complete
    send_value(24'h000000, 1'b0);
    send_value(24'h001000, 1'b1);
    // box cut short after its first score, negative corner
    send_coords(24'hFF0000, 24'h008000, 24'h7FFFFF, 24'h100000);
    send_value(24'h002400, 1'b1);

    for (p = 0; p < PhaseCount; p++) begin
      drain();
      setup_phase(p);
      gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      start = values_sent;
      do send_box();
      while (cur_classes < MaxClasses && values_sent - start < PhaseValues);
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("tb_top: %0d values in %0d boxes, %0d register writes, random gaps and stalls",
             values_sent, boxes_sent, reg_writes);
    $display("tb_top: %0d boxes decoded and compared, %0d dropped on score", decoded, dropped);
    if (errors == 0 && pending == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dbd_pkg.sv
rtl/dbd_accum.sv
rtl/dbd_scale.sv
rtl/dbd_clamp.sv
rtl/detection_box_decode_unit.sv
rtl/dbd_checker.sv
verif/dbd_checker.sv
verif/tb_top.sv
